// ===== rtl/jam_pkg.sv =====
// ----------------------------------------------------------------------------
// jam_pkg
// Shared types, character codes and lookup functions for the ack matcher.
// ----------------------------------------------------------------------------
package jam_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_ID    = 2'd1,
    CMD_TEXT  = 2'd2,
    CMD_END   = 2'd3
  } cmd_t;

  // One request as it leaves the input register and is processed.
  typedef struct packed {
    logic       valid;
    cmd_t       cmd;
    logic [7:0] data;
  } item_t;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_NUL    = 8'h00;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic [7:0] accepted_char(input logic [2:0] idx);
    case (idx)
      3'd0: return "A";
      3'd1: return "C";
      3'd2: return "C";
      3'd3: return "E";
      3'd4: return "P";
      3'd5: return "T";
      3'd6: return "E";
      default: return "D";
    endcase
  endfunction

  function automatic logic [7:0] key_event_char(input logic [2:0] idx);
    case (idx)
      3'd0: return "e";
      3'd1: return "v";
      3'd2: return "e";
      3'd3: return "n";
      3'd4: return "t";
      3'd5: return "_";
      3'd6: return "i";
      default: return "d";
    endcase
  endfunction

  function automatic logic [7:0] key_status_char(input logic [2:0] idx);
    case (idx)
      3'd0: return "s";
      3'd1: return "t";
      3'd2: return "a";
      3'd3: return "t";
      3'd4: return "u";
      3'd5: return "s";
      default: return CH_NUL;
    endcase
  endfunction

endpackage

// ===== rtl/jam_id_store.sv =====
// ----------------------------------------------------------------------------
// jam_id_store
// Holds the expected id in a memory with its length and load flags, and
// prefetches the stored byte that the next value byte will be compared with.
// ----------------------------------------------------------------------------
module jam_id_store
  import jam_pkg::*;
#(
  parameter int ID_MAX = 64,
  localparam int IW = $clog2(ID_MAX)
) (
  input  logic          clk,
  input  logic          rst,
  input  item_t         step,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output logic [7:0]    id_byte,
  output logic [IW-1:0] id_length,
  output logic          id_usable
);

  logic [7:0]    mem [ID_MAX];
  logic [7:0]    rd_q;
  logic          byp;
  logic [7:0]    byp_data;
  logic [IW-1:0] length;
  logic          closed;
  logic          too_long;

  logic          load;
  logic          we;

  assign load = step.valid && (step.cmd == CMD_ID) && !closed && !too_long;
  assign we   = load && (step.data != CH_NUL) && (length != IW'(ID_MAX - 1));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[length] <= step.data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      // A byte written in the same cycle is not yet visible in the array.
      byp      <= we && (length == rd_addr);
      byp_data <= step.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length   <= '0;
      closed   <= 1'b0;
      too_long <= 1'b0;
    end else if (step.valid && (step.cmd == CMD_START)) begin
      length   <= '0;
      closed   <= 1'b0;
      too_long <= 1'b0;
    end else if (load) begin
      if (step.data == CH_NUL) begin
        closed <= 1'b1;
      end else if (we) begin
        length <= length + 1'b1;
      end else begin
        too_long <= 1'b1;
      end
    end
  end

  assign id_byte   = byp ? byp_data : rd_q;
  assign id_length = length;
  assign id_usable = (length != '0) && !too_long;

endmodule

// ===== rtl/jam_parser.sv =====
// ----------------------------------------------------------------------------
// jam_parser
// Byte-at-a-time parser of the acknowledgement object, with key and value
// matching and the end-of-message verdict.
// ----------------------------------------------------------------------------
module jam_parser
  import jam_pkg::*;
#(
  parameter int ID_MAX = 64,
  parameter int SHORT_CAPACITY = 16,
  localparam int IW = $clog2(ID_MAX),
  localparam int KW = $clog2(SHORT_CAPACITY),
  localparam int CW = IW + 8
) (
  input  logic          clk,
  input  logic          rst,
  input  item_t         step,
  input  logic [7:0]    id_byte,
  input  logic [IW-1:0] id_length,
  input  logic          id_usable,
  output logic          match,
  output logic [IW-1:0] rd_addr
);

  typedef enum logic [2:0] {
    PH_OPEN, PH_MEMBER, PH_KEY, PH_COLON, PH_VOPEN, PH_VALUE, PH_AFTER, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_OTHER, KIND_EVENT, KIND_STATUS
  } kind_t;

  localparam logic [KW-1:0] KEY_LAST   = KW'(SHORT_CAPACITY - 1);
  localparam logic [KW-1:0] KEY_EV_LEN = KW'(8);
  localparam logic [KW-1:0] KEY_ST_LEN = KW'(6);
  localparam logic [IW-1:0] VAL_LAST   = IW'(ID_MAX - 1);
  localparam logic [CW-1:0] SHORT_LAST = CW'(SHORT_CAPACITY - 1);
  localparam logic [CW-1:0] ACC_LEN    = CW'(8);

  phase_t        phase, phase_next;
  logic          rejected, rejected_next;
  logic [KW-1:0] kpos, kpos_next;
  logic          kev, kev_next;
  logic          kst, kst_next;
  logic [IW-1:0] vpos, vpos_next;
  kind_t         kind, kind_next;
  logic          have_ev, have_ev_next;
  logic          have_st, have_st_next;
  logic          ev_eq, ev_eq_next;
  logic          st_eq, st_eq_next;

  logic [7:0]    b;
  logic [CW-1:0] vpos_wide;

  assign b         = step.data;
  assign vpos_wide = CW'(vpos);

  always_comb begin
    phase_next    = phase;
    rejected_next = rejected;
    kpos_next     = kpos;
    kev_next      = kev;
    kst_next      = kst;
    vpos_next     = vpos;
    kind_next     = kind;
    have_ev_next  = have_ev;
    have_st_next  = have_st;
    ev_eq_next    = ev_eq;
    st_eq_next    = st_eq;

    if (step.valid && ((step.cmd == CMD_START) || (step.cmd == CMD_END))) begin
      phase_next    = PH_OPEN;
      rejected_next = 1'b0;
      kpos_next     = '0;
      kev_next      = 1'b1;
      kst_next      = 1'b1;
      vpos_next     = '0;
      kind_next     = KIND_OTHER;
      have_ev_next  = 1'b0;
      have_st_next  = 1'b0;
      ev_eq_next    = 1'b0;
      st_eq_next    = 1'b0;
    end else if (step.valid && (step.cmd == CMD_TEXT) && !rejected) begin
      case (phase)
        PH_OPEN: begin
          if (b == CH_LBRACE) begin
            phase_next = PH_MEMBER;
          end else if (!is_space(b)) begin
            rejected_next = 1'b1;
          end
        end
        PH_MEMBER: begin
          if (b == CH_RBRACE) begin
            phase_next = PH_DONE;
          end else if (b == CH_QUOTE) begin
            phase_next = PH_KEY;
            kpos_next  = '0;
            kev_next   = 1'b1;
            kst_next   = 1'b1;
          end else if (!is_space(b)) begin
            rejected_next = 1'b1;
          end
        end
        PH_KEY: begin
          if (b == CH_QUOTE) begin
            if (kev && (kpos == KEY_EV_LEN) && !have_ev) begin
              kind_next  = KIND_EVENT;
              ev_eq_next = 1'b1;
              phase_next = PH_COLON;
            end else if (kst && (kpos == KEY_ST_LEN) && !have_st) begin
              kind_next  = KIND_STATUS;
              st_eq_next = 1'b1;
              phase_next = PH_COLON;
            end else begin
              rejected_next = 1'b1;
            end
          end else if ((b < CH_SPACE) || (b == CH_BSLASH) || (kpos == KEY_LAST)) begin
            rejected_next = 1'b1;
          end else begin
            if ((kpos >= KEY_EV_LEN) || (key_event_char(kpos[2:0]) != b)) begin
              kev_next = 1'b0;
            end
            if ((kpos >= KEY_ST_LEN) || (key_status_char(kpos[2:0]) != b)) begin
              kst_next = 1'b0;
            end
            kpos_next = kpos + 1'b1;
          end
        end
        PH_COLON: begin
          if (b == CH_COLON) begin
            phase_next = PH_VOPEN;
          end else if (!is_space(b)) begin
            rejected_next = 1'b1;
          end
        end
        PH_VOPEN: begin
          if (b == CH_QUOTE) begin
            phase_next = PH_VALUE;
            vpos_next  = '0;
          end else if (!is_space(b)) begin
            rejected_next = 1'b1;
          end
        end
        PH_VALUE: begin
          if (b == CH_QUOTE) begin
            if (kind == KIND_EVENT) begin
              if (vpos != id_length) begin
                ev_eq_next = 1'b0;
              end
              have_ev_next = 1'b1;
            end else begin
              if (vpos_wide != ACC_LEN) begin
                st_eq_next = 1'b0;
              end
              have_st_next = 1'b1;
            end
            phase_next = PH_AFTER;
          end else if ((b < CH_SPACE) || (b == CH_BSLASH) || (vpos == VAL_LAST)) begin
            rejected_next = 1'b1;
          end else if (kind == KIND_EVENT) begin
            if ((vpos >= id_length) || (id_byte != b)) begin
              ev_eq_next = 1'b0;
            end
            vpos_next = vpos + 1'b1;
          end else if (vpos_wide >= SHORT_LAST) begin
            rejected_next = 1'b1;
          end else begin
            if ((vpos_wide >= ACC_LEN) || (accepted_char(vpos_wide[2:0]) != b)) begin
              st_eq_next = 1'b0;
            end
            vpos_next = vpos + 1'b1;
          end
        end
        PH_AFTER: begin
          if (b == CH_COMMA) begin
            phase_next = PH_MEMBER;
          end else if (b == CH_RBRACE) begin
            phase_next = PH_DONE;
          end else if (!is_space(b)) begin
            rejected_next = 1'b1;
          end
        end
        default: begin
          if (!is_space(b)) begin
            rejected_next = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_OPEN;
      rejected <= 1'b0;
      kpos     <= '0;
      kev      <= 1'b1;
      kst      <= 1'b1;
      vpos     <= '0;
      kind     <= KIND_OTHER;
      have_ev  <= 1'b0;
      have_st  <= 1'b0;
      ev_eq    <= 1'b0;
      st_eq    <= 1'b0;
    end else begin
      phase    <= phase_next;
      rejected <= rejected_next;
      kpos     <= kpos_next;
      kev      <= kev_next;
      kst      <= kst_next;
      vpos     <= vpos_next;
      kind     <= kind_next;
      have_ev  <= have_ev_next;
      have_st  <= have_st_next;
      ev_eq    <= ev_eq_next;
      st_eq    <= st_eq_next;
    end
  end

  // The next request compares against the byte at the position this one leaves.
  assign rd_addr = vpos_next;

  assign match = !rejected && (phase == PH_DONE) && have_ev && have_st &&
                 ev_eq && st_eq && id_usable;

endmodule

// ===== rtl/json_ack_matcher.sv =====
// ----------------------------------------------------------------------------
// json_ack_matcher
// Throughput: one request per cycle, except while an end request waits behind an
// unclaimed verdict; each request is processed from the input register, and matched
// is registered as an end request leaves it. The rate is set by the parser state loop
// and the id memory read, which is prefetched as the request enters the input register.
// Reset clears the parser, the id length and both registers; no clearing pass.
// ----------------------------------------------------------------------------
module json_ack_matcher
  import jam_pkg::*;
#(
  parameter int ID_MAX = 64,
  parameter int SHORT_CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] command,
  input  logic [7:0] data_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       matched
);

  localparam int IW = $clog2(ID_MAX);

  logic          a_valid;
  cmd_t          a_cmd;
  logic [7:0]    a_data;
  logic          a_done;
  logic          a_load;
  item_t         step;
  logic [7:0]    id_byte;
  logic [IW-1:0] id_length;
  logic          id_usable;
  logic          match;
  logic [IW-1:0] rd_addr;

  // Only an end request waits, and only while the previous verdict is unclaimed.
  assign a_done     = a_valid && ((a_cmd != CMD_END) || !result_valid || !result_stall);
  assign item_stall = a_valid && !a_done;
  assign a_load     = item_valid && !item_stall;

  assign step.valid = a_done;
  assign step.cmd   = a_cmd;
  assign step.data  = a_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_load) begin
      a_valid <= 1'b1;
    end else if (a_done) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_cmd  <= cmd_t'(command);
      a_data <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (a_done && (a_cmd == CMD_END)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_done && (a_cmd == CMD_END)) begin
      matched <= match;
    end
  end

  jam_id_store #(
    .ID_MAX (ID_MAX)
  ) u_id_store (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rd_en     (a_load),
    .rd_addr   (rd_addr),
    .id_byte   (id_byte),
    .id_length (id_length),
    .id_usable (id_usable)
  );

  jam_parser #(
    .ID_MAX         (ID_MAX),
    .SHORT_CAPACITY (SHORT_CAPACITY)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .id_byte   (id_byte),
    .id_length (id_length),
    .id_usable (id_usable),
    .match     (match),
    .rd_addr   (rd_addr)
  );

endmodule

// ===== rtl/jam_checker.sv =====
// ----------------------------------------------------------------------------
// jam_checker
// Port-level checks of the ack matcher, bound to the top level.
// ----------------------------------------------------------------------------
module jam_checker
  import jam_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_stall,
  input logic [1:0] command,
  input logic       result_valid,
  input logic       result_stall,
  input logic       matched
);

  // A held verdict stays put until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(matched))
    else $error("verdict changed while stalled");

  // The input only waits behind an unclaimed verdict.
  assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled without a pending verdict");

  // A fresh verdict follows an end request that passed the input register and the verdict register.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_valid && !item_stall && (command == CMD_END), 2))
    else $error("verdict without an end request");

  // Reset leaves no verdict behind.
  assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("verdict present after reset");

endmodule

bind json_ack_matcher jam_checker u_jam_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .command      (command),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .matched      (matched)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for json_ack_matcher
// Requests are mostly built as whole acknowledgement messages (id load, JSON text,
// end) with random content, corruption and noise. They are driven from a
// queue, and every request taken is run through a cycle-free copy of the
// parser. Each answer is compared with the oldest predicted answer.
// ----------------------------------------------------------------------------
module tb_top
  import jam_pkg::*;
();

  localparam int ID_MAX      = 64;
  localparam int SHORT_CAP   = 16;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 500000;

  localparam logic [63:0] EVENT_KEY     = {"event", "_id"};
  localparam logic [47:0] STATUS_KEY    = "status";
  localparam logic [63:0] ACCEPTED_WORD = "ACCEPTED";

  typedef enum logic [2:0] {
    P_OPEN, P_MEMBER, P_KEY, P_COLON, P_VOPEN, P_VALUE, P_AFTER, P_DONE
  } phase_t;

  typedef enum logic [1:0] {
    V_OTHER, V_EVENT, V_STATUS
  } vkind_t;

  typedef struct {
    cmd_t       cmd;
    logic [7:0] data;
    bit         hold;
    bit         drain;
    bit         calm;
  } req_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic [1:0] command = CMD_START;
  logic [7:0] data_byte = 8'h00;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic       matched;

  json_ack_matcher #(
    .ID_MAX(ID_MAX),
    .SHORT_CAPACITY(SHORT_CAP)
  ) uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .command(command),
    .data_byte(data_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .matched(matched)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Parser state as the block should hold it
  phase_t      ph;
  bit          bad;
  int unsigned kpos;
  bit          maybe_event;
  bit          maybe_status;
  int unsigned vpos;
  vkind_t      vkind;
  bit          got_event;
  bit          got_status;
  bit          event_same;
  bit          status_same;
  logic [7:0]  id_mem [ID_MAX];
  int unsigned id_len;
  bit          id_closed;
  bit          id_overlong;

  logic matched_due[$];

  req_t       pending[$];
  logic [7:0] text_q[$];
  logic [7:0] id_plan[$];
  bit         mark_hold = 1'b0;
  bit         mark_drain = 1'b0;
  bit         calm_mode = 1'b0;
  int         items_queued = 0;
  int         ends_queued = 0;

  int   errors = 0;
  int   reqs_taken = 0;
  int   answers_seen = 0;
  int   matches_seen = 0;
  int   holds_done = 0;
  int   cycle_count = 0;
  logic item_fire = 1'b0;
  logic hold_req = 1'b0;
  logic calm_phase = 1'b0;
  int   gap_cnt = 0;
  int   rx_gap = 0;
  int   long_hold = 0;
  int   tx_idle_pct = 10;
  int   rx_idle_pct = 10;

  task automatic note_mismatch(string what, logic want, logic got);
    errors++;
    $display("MISMATCH cycle %0d: %s, expected %b, got %b", cycle_count, what, want, got);
  endtask

  function automatic bit blank(logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic void clear_parse();
    ph = P_OPEN;
    bad = 1'b0;
    kpos = 0;
    maybe_event = 1'b1;
    maybe_status = 1'b1;
    vpos = 0;
    vkind = V_OTHER;
    got_event = 1'b0;
    got_status = 1'b0;
    event_same = 1'b0;
    status_same = 1'b0;
  endfunction

  function automatic void clear_id();
    for (int i = 0; i < ID_MAX; i++) id_mem[i] = 8'h00;
    id_len = 0;
    id_closed = 1'b0;
    id_overlong = 1'b0;
  endfunction

  function automatic void parse_text(logic [7:0] b);
    int unsigned p;
    if (bad) return;
    case (ph)
      P_OPEN: begin
        if (!blank(b)) begin
          if (b == CH_LBRACE) ph = P_MEMBER;
          else bad = 1'b1;
        end
      end
      P_MEMBER: begin
        if (!blank(b)) begin
          if (b == CH_RBRACE) ph = P_DONE;
          else if (b == CH_QUOTE) begin
            ph = P_KEY;
            kpos = 0;
            maybe_event = 1'b1;
            maybe_status = 1'b1;
          end else bad = 1'b1;
        end
      end
      P_KEY: begin
        if (b == CH_QUOTE) begin
          // The key is judged only once its closing quote is seen.
          if (maybe_event && kpos == 8 && !got_event) begin
            vkind = V_EVENT;
            event_same = 1'b1;
            ph = P_COLON;
          end else if (maybe_status && kpos == 6 && !got_status) begin
            vkind = V_STATUS;
            status_same = 1'b1;
            ph = P_COLON;
          end else bad = 1'b1;
        end else if (b < 8'h20 || b == CH_BSLASH || kpos + 1 >= SHORT_CAP) begin
          bad = 1'b1;
        end else begin
          if (kpos >= 8) maybe_event = 1'b0;
          else if (EVENT_KEY[63 - 8 * kpos -: 8] != b) maybe_event = 1'b0;
          if (kpos >= 6) maybe_status = 1'b0;
          else if (STATUS_KEY[47 - 8 * kpos -: 8] != b) maybe_status = 1'b0;
          kpos++;
        end
      end
      P_COLON: begin
        if (!blank(b)) begin
          if (b == CH_COLON) ph = P_VOPEN;
          else bad = 1'b1;
        end
      end
      P_VOPEN: begin
        if (!blank(b)) begin
          if (b == CH_QUOTE) begin
            ph = P_VALUE;
            vpos = 0;
          end else bad = 1'b1;
        end
      end
      P_VALUE: begin
        if (b == CH_QUOTE) begin
          if (vkind == V_EVENT) begin
            if (vpos != id_len) event_same = 1'b0;
            got_event = 1'b1;
          end else begin
            if (vpos != 8) status_same = 1'b0;
            got_status = 1'b1;
          end
          ph = P_AFTER;
        end else begin
          p = vpos;
          if (b < 8'h20 || b == CH_BSLASH || p + 1 >= ID_MAX) begin
            bad = 1'b1;
          end else if (vkind == V_EVENT) begin
            if (p >= id_len) event_same = 1'b0;
            else if (id_mem[p] != b) event_same = 1'b0;
            vpos = p + 1;
          end else if (p + 1 >= SHORT_CAP) begin
            bad = 1'b1;
          end else begin
            if (p >= 8) status_same = 1'b0;
            else if (ACCEPTED_WORD[63 - 8 * p -: 8] != b) status_same = 1'b0;
            vpos = p + 1;
          end
        end
      end
      P_AFTER: begin
        if (!blank(b)) begin
          if (b == CH_COMMA) ph = P_MEMBER;
          else if (b == CH_RBRACE) ph = P_DONE;
          else bad = 1'b1;
        end
      end
      default: begin
        if (!blank(b)) bad = 1'b1;
      end
    endcase
  endfunction

  // Applies one taken request and queues the answer that it is due to give.
  function automatic void step_ack_check(cmd_t c, logic [7:0] b);
    case (c)
      CMD_START: begin
        clear_parse();
        clear_id();
      end
      CMD_ID: begin
        if (!id_closed && !id_overlong) begin
          if (b == CH_NUL) id_closed = 1'b1;
          else if (id_len < ID_MAX - 1) begin
            id_mem[id_len] = b;
            id_len++;
          end else id_overlong = 1'b1;
        end
      end
      CMD_TEXT: parse_text(b);
      default: begin
        matched_due.push_back(!bad && ph == P_DONE && got_event && got_status &&
                              event_same && status_same && id_len > 0 && !id_overlong);
        clear_parse();
      end
    endcase
  endfunction

  function automatic int idle_level();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 8;
      default: return 30;
    endcase
  endfunction

  function automatic void push_req(cmd_t c, logic [7:0] d);
    pending.push_back('{cmd: c, data: d, hold: mark_hold, drain: mark_drain, calm: calm_mode});
    mark_hold = 1'b0;
    mark_drain = 1'b0;
    items_queued++;
    if (c == CMD_END) ends_queued++;
  endfunction

  // Any byte that may legally sit inside a string.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(8'h20, 8'hFF)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(8'(s[i]));
  endfunction

  // Pushes the last n characters of a packed word, leftmost first.
  function automatic void add_word(logic [63:0] w, int n);
    for (int i = n - 1; i >= 0; i--) text_q.push_back(w[8 * i +: 8]);
  endfunction

  function automatic void add_ws();
    int n;
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        n = $urandom_range(0, 6);
        text_q.push_back(n >= 5 ? 8'h20 : 8'(8'h09 + n));
      end
    end
  endfunction

  function automatic void queue_message();
    int         n;
    int         pick;
    int         k;
    int         cut;
    int         order[$];
    logic [7:0] b;
    text_q.delete();
    // An end keeps the stored id, so now and then the next message reuses it.
    if (id_plan.size() == 0 || $urandom_range(0, 9) != 0) begin
      push_req(CMD_START, 8'($urandom));
      id_plan.delete();
      pick = $urandom_range(0, 11);
      n = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(60, 66) : $urandom_range(1, 10);
      repeat (n) begin
        b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : plain_byte();
        id_plan.push_back(b);
        push_req(CMD_ID, b);
      end
      if ($urandom_range(0, 2) == 0) begin
        push_req(CMD_ID, CH_NUL);
        repeat ($urandom_range(0, 3)) push_req(CMD_ID, 8'($urandom));
      end
    end

    if ($urandom_range(0, 1) == 1) order = '{1, 0};
    else order = '{0, 1};
    if ($urandom_range(0, 9) == 0) void'(order.pop_front());
    if ($urandom_range(0, 19) == 0) order.delete();
    if ($urandom_range(0, 14) == 0) order.insert($urandom_range(0, order.size()),
                                                 $urandom_range(0, 1));
    if ($urandom_range(0, 14) == 0) order.insert($urandom_range(0, order.size()), 2);

    add_ws();
    text_q.push_back(CH_LBRACE);
    foreach (order[i]) begin
      if (i > 0) text_q.push_back(CH_COMMA);
      add_ws();
      text_q.push_back(CH_QUOTE);
      case (order[i])
        0: add_word(EVENT_KEY, 8);
        1: add_text("status");
        default: begin
          k = $urandom_range(0, 2);
          if (k == 0) add_text("event_i");
          else if (k == 1) add_text("statuses");
          repeat ($urandom_range(0, 18)) text_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
        end
      endcase
      text_q.push_back(CH_QUOTE);
      add_ws();
      text_q.push_back(CH_COLON);
      add_ws();
      text_q.push_back(CH_QUOTE);
      if (order[i] == 0) begin
        foreach (id_plan[j]) text_q.push_back(id_plan[j]);
        pick = $urandom_range(0, 9);
        if (pick == 0) text_q.push_back(plain_byte());
        else if (pick == 1 && id_plan.size() > 0) void'(text_q.pop_back());
        else if (pick == 2 && id_plan.size() > 0) text_q[text_q.size() - 1] = plain_byte();
      end else if (order[i] == 1) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) add_text("ACCEPTED");
        else if (pick == 6) add_text("ACCEPTE");
        else if (pick == 7) add_text("ACCEPTEDs");
        else if (pick == 8) add_text("REJECTED");
        else repeat ($urandom_range(0, 20)) text_q.push_back(plain_byte());
      end else begin
        repeat ($urandom_range(0, 20)) text_q.push_back(plain_byte());
      end
      text_q.push_back(CH_QUOTE);
      add_ws();
    end
    if (order.size() > 0 && $urandom_range(0, 3) == 0) begin
      text_q.push_back(CH_COMMA);
      add_ws();
    end
    text_q.push_back(CH_RBRACE);
    add_ws();

    // Broken messages: a stray byte, a control byte, a backslash, a lost byte,
    // rubbish after the object or a missing tail.
    if ($urandom_range(0, 5) == 0) begin
      k = $urandom_range(0, text_q.size() - 1);
      case ($urandom_range(0, 3))
        0: text_q[k] = 8'($urandom);
        1: text_q.insert(k, 8'($urandom_range(0, 31)));
        2: text_q.insert(k, CH_BSLASH);
        default: text_q.delete(k);
      endcase
    end
    if ($urandom_range(0, 14) == 0) text_q.push_back(8'($urandom));
    if ($urandom_range(0, 19) == 0) repeat ($urandom_range(1, 3)) begin
      if (text_q.size() > 1) void'(text_q.pop_back());
    end

    cut = ($urandom_range(0, 14) == 0) ? $urandom_range(0, text_q.size()) : -1;
    foreach (text_q[j]) begin
      if (j == cut) push_req(CMD_ID, 8'($urandom));
      push_req(CMD_TEXT, text_q[j]);
    end
    push_req(CMD_END, 8'($urandom));
    if ($urandom_range(0, 19) == 0) push_req(CMD_END, 8'($urandom));
  endfunction

  // Answer checking and prediction; the check comes first so that an answer
  // can never be matched against a request taken at the same edge.
  always @(posedge clk) begin
    logic want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        answers_seen++;
        if (matched === 1'b1) matches_seen++;
        if (matched_due.size() == 0) begin
          note_mismatch("answer with none outstanding", 1'bx, matched);
        end else begin
          want = matched_due.pop_front();
          if (matched !== want) note_mismatch("matched", want, matched);
        end
      end
      if (item_valid && !item_stall) begin
        reqs_taken++;
        step_ack_check(cmd_t'(command), data_byte);
      end
    end
    item_fire <= !rst && item_valid && !item_stall;
  end

  // Request driver
  always @(negedge clk) begin
    req_t nxt;
    logic offer;
    logic want_hold;
    offer = item_valid && !item_fire;
    want_hold = 1'b0;
    if (!rst && !offer) begin
      if (gap_cnt > 0) begin
        gap_cnt--;
      end else if (pending.size() > 0 && !(pending[0].drain && matched_due.size() > 0)) begin
        nxt = pending.pop_front();
        offer = 1'b1;
        command <= nxt.cmd;
        data_byte <= nxt.data;
        calm_phase <= nxt.calm;
        want_hold = nxt.hold;
        if (!nxt.calm && $urandom_range(0, 99) < tx_idle_pct) gap_cnt = $urandom_range(1, 19);
        if ($urandom_range(0, 39) == 0) tx_idle_pct = idle_level();
      end
    end
    item_valid <= offer;
    hold_req <= want_hold;
  end

  // Answer receiver
  always @(negedge clk) begin
    if (!rst) begin
      if (long_hold > 0) begin
        long_hold--;
        result_stall <= 1'b1;
      end else if (hold_req) begin
        long_hold = LONG_HOLD;
        holds_done++;
        result_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        result_stall <= 1'b1;
      end else if (!calm_phase && $urandom_range(0, 99) < rx_idle_pct) begin
        rx_gap = $urandom_range(0, 18);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
      if ($urandom_range(0, 49) == 0) rx_idle_pct = idle_level();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("json_ack_matcher verification failed");
      $finish;
    end
  end

  initial begin
    bit held;
    held = 1'b0;
    clear_parse();
    clear_id();

    // Directed opening: end before any load, an id closed by a zero byte,
    // an empty object, whitespace edges and data extremes.
    push_req(CMD_END, 8'h00);
    push_req(CMD_START, 8'hFF);
    push_req(CMD_ID, 8'h41);
    push_req(CMD_ID, CH_NUL);
    push_req(CMD_ID, 8'hFF);
    push_req(CMD_TEXT, 8'h09);
    push_req(CMD_TEXT, CH_LBRACE);
    push_req(CMD_TEXT, 8'h0D);
    push_req(CMD_TEXT, CH_RBRACE);
    push_req(CMD_END, 8'hFF);
    push_req(CMD_TEXT, 8'hFF);
    push_req(CMD_END, 8'h00);
    push_req(CMD_TEXT, CH_LBRACE);
    push_req(CMD_TEXT, 8'h0E);
    push_req(CMD_END, 8'h00);
    push_req(CMD_START, 8'h00);
    push_req(CMD_ID, CH_NUL);
    push_req(CMD_TEXT, 8'h00);
    push_req(CMD_END, 8'h00);

    while (items_queued < 580 || ends_queued < 12) begin
      calm_mode = items_queued >= 500;
      if (!held && items_queued > 300) begin
        // Hold the answers back while ends keep arriving, then wait for
        // every answer before the next message goes out.
        held = 1'b1;
        mark_hold = 1'b1;
        repeat (6) begin
          push_req(CMD_START, 8'($urandom));
          push_req(CMD_ID, 8'h6B);
          push_req(CMD_TEXT, CH_LBRACE);
          push_req(CMD_END, 8'($urandom));
        end
        mark_drain = 1'b1;
      end
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(5, 30)) push_req(cmd_t'($urandom_range(0, 3)), 8'($urandom));
        push_req(CMD_END, 8'($urandom));
      end else begin
        queue_message();
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || item_valid || matched_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (matched_due.size() != 0) note_mismatch("answers never delivered", 1'b1, 1'b0);

    $display("Run covered %0d requests and %0d checked answers, %0d of them matches.",
             reqs_taken, answers_seen, matches_seen);
    $display("Answers were held back for a long stretch %0d time(s); %0d mismatch(es).",
             holds_done, errors);
    if (errors == 0) begin
      $display("json_ack_matcher verification clean");
    end else begin
      $display("json_ack_matcher verification failed");
    end
    $finish;
  end

endmodule
